// File: design/dspm_pkg.sv
`default_nettype none

package dspm_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_FINISH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    typedef struct packed {
        t_op        op;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/dspm_nfa.sv
`default_nettype none

module dspm_nfa
    import dspm_pkg::*;
#(
    parameter int N = 32
) (
    input  wire logic [N:0]        i_active,
    input  wire logic [N-1:0]      i_valid_tok,
    input  wire logic [N-1:0]      i_star,
    input  wire logic [N-1:0][7:0] i_tok_byte,
    input  wire logic [7:0]        i_symbol,
    output logic      [N:0]        o_closed,
    output logic      [N:0]        o_next
);

    localparam int NP = N + 1;
    localparam int LV = $clog2(NP);

    logic [N-1:0]  star_m;
    logic [NP-1:0] g [LV+1];
    logic [NP-1:0] p [LV+1];
    logic [N-1:0]  hit;
    logic [N-1:0]  m;

    assign star_m = i_star & i_valid_tok;
    assign g[0]   = i_active;
    assign p[0]   = {star_m, 1'b0};

    // closure over starred runs as a parallel prefix
    for (genvar lv = 0; lv < LV; lv++) begin : g_lvl
        for (genvar i = 0; i < NP; i++) begin : g_bit
            if (i >= (1 << lv)) begin : g_comb
                assign g[lv+1][i] = g[lv][i] | (p[lv][i] & g[lv][i-(1<<lv)]);
                assign p[lv+1][i] = p[lv][i] & p[lv][i-(1<<lv)];
            end else begin : g_pass
                assign g[lv+1][i] = g[lv][i];
                assign p[lv+1][i] = p[lv][i];
            end
        end
    end

    assign o_closed = g[LV];

    for (genvar i = 0; i < N; i++) begin : g_hit
        assign hit[i] = (i_tok_byte[i] == i_symbol) || (i_tok_byte[i] == DOT_BYTE);
    end

    assign m      = i_valid_tok & o_closed[N-1:0] & hit;
    assign o_next = {1'b0, m & i_star} | {m & ~i_star, 1'b0};

endmodule

`default_nettype wire

// File: design/dot_star_pattern_matcher.sv
// Channel | Valid      | Ready       | Payload
// input   | i_in_valid | o_in_ready  | i_in_data  (t_in_item: op, symbol)
// output  | o_out_valid| i_out_ready | o_out_data (t_out_item: matched, overflow)
//
// One request per cycle on every op while the output is not stalled; a finish result appears the cycle after accept.
// The NFA step and closure (prefix tree over MAX_TOKENS+1 positions) are combinational.
// Reset leaves an empty pattern with only position zero active; no clearing pass.
// A held result stalls input only while the output register is full and not taken.
`default_nettype none

module dot_star_pattern_matcher
    import dspm_pkg::*;
#(
    parameter int MAX_TOKENS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam int CW = $clog2(MAX_TOKENS + 1);

    logic [MAX_TOKENS-1:0][7:0] r_tok_byte;
    logic [MAX_TOKENS-1:0]      r_tok_star;
    logic [CW-1:0]              r_count;
    logic [MAX_TOKENS:0]        r_active;
    logic                       r_ovf;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [MAX_TOKENS-1:0] valid_tok;
    logic [MAX_TOKENS:0]   closed;
    logic [MAX_TOKENS:0]   n_active;
    logic                  accept;
    logic                  last_star;
    logic                  star_hit;
    logic                  full;
    logic                  matched;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_vld
        assign valid_tok[i] = CW'(i) < r_count;
    end

    always_comb begin
        last_star = 1'b0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            if (r_count == CW'(i + 1)) begin
                last_star = r_tok_star[i];
            end
        end
    end

    always_comb begin
        matched = 1'b0;
        for (int i = 0; i <= MAX_TOKENS; i++) begin
            if (r_count == CW'(i)) begin
                matched = closed[i];
            end
        end
    end

    assign star_hit = (i_in_data.symbol == STAR_BYTE) && (r_count != '0) && !last_star;
    assign full     = r_count == CW'(MAX_TOKENS);

    dspm_nfa #(
        .N (MAX_TOKENS)
    ) u_nfa (
        .i_active    (r_active),
        .i_valid_tok (valid_tok),
        .i_star      (r_tok_star),
        .i_tok_byte  (r_tok_byte),
        .i_symbol    (i_in_data.symbol),
        .o_closed    (closed),
        .o_next      (n_active)
    );

    // token store and result payload
    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.op == OP_APPEND) begin
            for (int i = 0; i < MAX_TOKENS; i++) begin
                if (star_hit && r_count == CW'(i + 1)) begin
                    r_tok_star[i] <= 1'b1;
                end else if (!star_hit && r_count == CW'(i)) begin
                    r_tok_byte[i] <= i_in_data.symbol;
                    r_tok_star[i] <= 1'b0;
                end
            end
        end
        if (accept && i_in_data.op == OP_FINISH) begin
            r_out.matched  <= matched;
            r_out.overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_active    <= (MAX_TOKENS + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (accept && i_in_data.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                case (i_in_data.op)
                    OP_APPEND: begin
                        if (!star_hit) begin
                            if (full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                    OP_TEXT: begin
                        r_active <= n_active;
                    end
                    OP_FINISH: begin
                        r_active <= (MAX_TOKENS + 1)'(1);
                    end
                    OP_CLEAR: begin
                        r_count  <= '0;
                        r_ovf    <= 1'b0;
                        r_active <= (MAX_TOKENS + 1)'(1);
                    end
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: design/dspm_checker.sv
`default_nettype none

module dspm_checker
    import dspm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result register is stalled");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.op == OP_FINISH |=> o_out_valid)
        else $error("finish request gave no result");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_CLEAR) ##1 (in_acc && i_in_data.op == OP_FINISH)
        |=> o_out_data.matched && !o_out_data.overflow)
        else $error("empty pattern after clear must match with no overflow");

endmodule

bind dot_star_pattern_matcher dspm_checker u_dspm_checker (.*);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb
    import dspm_pkg::*;
();

    localparam int MAX_TOK     = 32;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    class match_scoreboard;
        logic [7:0]     pat_byte [MAX_TOK];
        bit             pat_star [MAX_TOK];
        int             pat_len;
        logic [MAX_TOK:0] live;
        bit             pat_ovf;
        t_out_item      expected_reports[$];
        int             errors;

        function new();
            pat_len = 0;
            pat_ovf = 0;
            live    = 1;
            errors  = 0;
        endfunction

        function logic [MAX_TOK:0] closure(logic [MAX_TOK:0] s);
            for (int p = 0; p < pat_len; p++) begin
                if (s[p] && pat_star[p]) begin
                    s[p+1] = 1'b1;
                end
            end
            return s;
        endfunction

        function void note_request(t_in_item r);
            logic [MAX_TOK:0] cur;
            logic [MAX_TOK:0] nxt;
            t_out_item rpt;
            case (r.op)
                OP_APPEND: begin
                    if (r.symbol == STAR_BYTE && pat_len > 0 && !pat_star[pat_len-1]) begin
                        pat_star[pat_len-1] = 1;
                    end else if (pat_len >= MAX_TOK) begin
                        pat_ovf = 1;
                    end else begin
                        pat_byte[pat_len] = r.symbol;
                        pat_star[pat_len] = 0;
                        pat_len++;
                    end
                end
                OP_TEXT: begin
                    cur = closure(live);
                    nxt = '0;
                    for (int p = 0; p < pat_len; p++) begin
                        if (cur[p] && (pat_byte[p] == r.symbol || pat_byte[p] == DOT_BYTE)) begin
                            if (pat_star[p]) nxt[p] = 1'b1;
                            else nxt[p+1] = 1'b1;
                        end
                    end
                    live = nxt;
                end
                OP_FINISH: begin
                    cur = closure(live);
                    rpt.matched  = cur[pat_len];
                    rpt.overflow = pat_ovf;
                    expected_reports.push_back(rpt);
                    live = 1;
                end
                default: begin
                    pat_len = 0;
                    pat_ovf = 0;
                    live    = 1;
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected report: matched %0d overflow %0d",
                                           got.matched, got.overflow);
                return;
            end
            want = expected_reports.pop_front();
            if (got.matched !== want.matched) begin
                errors++;
                if (errors <= 10) $display("matched mismatch: expected %0d got %0d",
                                           want.matched, got.matched);
            end
            if (got.overflow !== want.overflow) begin
                errors++;
                if (errors <= 10) $display("overflow mismatch: expected %0d got %0d",
                                           want.overflow, got.overflow);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    match_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int requests_sent;
    int cycles;
    bit hold_go;
    bit hold_active;

    dot_star_pattern_matcher #(.MAX_TOKENS(MAX_TOK)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL dot_star_pattern_matcher");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_request(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_active) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the result register fills and input backs up
    initial begin
        hold_active = 0;
        wait (hold_go);
        @(posedge i_clk);
        hold_active = 1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 0;
    end

    task automatic drive_request(input t_op op, input logic [7:0] sym);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{op: op, symbol: sym};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return "a";
        if (r < 60) return "b";
        if (r < 75) return DOT_BYTE;
        if (r < 92) return STAR_BYTE;
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        int n;
        int copies;
        int runs;
        int pat_target;
        logic [7:0] b;

        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        hold_go        = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pattern against empty text
        drive_request(OP_FINISH, 8'hFF);
        // leading star is literal, second stars it, third is literal again
        drive_request(OP_APPEND, STAR_BYTE);
        drive_request(OP_APPEND, STAR_BYTE);
        drive_request(OP_APPEND, STAR_BYTE);
        drive_request(OP_TEXT, STAR_BYTE);
        drive_request(OP_TEXT, STAR_BYTE);
        drive_request(OP_FINISH, 8'h00);
        drive_request(OP_CLEAR, 8'hFF);
        drive_request(OP_APPEND, DOT_BYTE);
        drive_request(OP_APPEND, STAR_BYTE);
        drive_request(OP_APPEND, 8'hFF);
        drive_request(OP_TEXT, 8'h00);
        drive_request(OP_TEXT, 8'hFF);
        drive_request(OP_FINISH, 8'h55);
        drive_request(OP_CLEAR, 8'h00);
        drive_request(OP_APPEND, 8'h00);
        drive_request(OP_TEXT, 8'hFF);
        drive_request(OP_FINISH, 8'hAA);
        drive_request(OP_FINISH, 8'h00);
        // pattern change in the middle of text
        drive_request(OP_TEXT, 8'h00);
        drive_request(OP_APPEND, STAR_BYTE);
        drive_request(OP_TEXT, 8'h00);
        drive_request(OP_FINISH, 8'h00);

        hold_go = 1;
        repeat (2) @(negedge i_clk);
        for (int i = 0; i < 12; i++) begin
            drive_request((i % 3 == 0) ? OP_TEXT : OP_FINISH, 8'($urandom));
        end

        while (requests_sent < ITEM_TARGET) begin
            case ((requests_sent * 4) / ITEM_TARGET)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase

            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    drive_request(t_op'($urandom_range(0, 3)), 8'($urandom));
                end
                continue;
            end

            if ($urandom_range(0, 2) == 0) drive_request(OP_CLEAR, 8'($urandom));
            pat_target = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40)
                                                      : $urandom_range(0, 6);
            for (int i = 0; i < pat_target; i++) drive_request(OP_APPEND, pick_symbol());

            runs = $urandom_range(1, 3);
            for (int r = 0; r < runs; r++) begin
                if ($urandom_range(0, 9) < 6) begin
                    for (int p = 0; p < sb.pat_len; p++) begin
                        copies = sb.pat_star[p] ? $urandom_range(0, 2) : 1;
                        for (int c = 0; c < copies; c++) begin
                            b = (sb.pat_byte[p] == DOT_BYTE) ? 8'($urandom) : sb.pat_byte[p];
                            if ($urandom_range(0, 29) == 0) b = pick_symbol();
                            drive_request(OP_TEXT, b);
                        end
                    end
                end else begin
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++) begin
                        drive_request(OP_TEXT, pick_symbol());
                        if ($urandom_range(0, 19) == 0) drive_request(OP_APPEND, pick_symbol());
                    end
                end
                if ($urandom_range(0, 9) != 0) drive_request(OP_FINISH, 8'($urandom));
            end
        end

        i_in_valid     <= 1'b0;
        recv_stall_pct = 0;
        while (sb.expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
            $display("PASS dot_star_pattern_matcher");
        end else begin
            $display("FAIL dot_star_pattern_matcher");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/dspm_pkg.sv
design/dspm_nfa.sv
design/dot_star_pattern_matcher.sv
design/dspm_checker.sv
bench/tb.sv
